// ----- sv/msp_frame_receiver_macros.svh -----
// ============================================================================
// msp_frame_receiver_macros.svh
// Assertion macros shared by the frame receiver RTL.
// ============================================================================
`ifndef MSP_FRAME_RECEIVER_MACROS_SVH
`define MSP_FRAME_RECEIVER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define MSPFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define MSPFR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MSPFR_ASSERT(lbl, prop, msg)
`define MSPFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/mspfr_pkg.sv -----
// ============================================================================
// mspfr_pkg
// Types and constants of the MSP v1 frame receiver.
// ============================================================================
package mspfr_pkg;

    localparam int PAYLOAD_MAX = 64;
    localparam int ADDR_W      = $clog2(PAYLOAD_MAX);
    localparam int SIZE_W      = 7;
    localparam int IDX_W       = 6;

    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_M     = 8'h4D;  // 'M'
    localparam logic [7:0] CH_LT    = 8'h3C;  // '<' command frame
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>' reply frame

    localparam logic REG_CLIENT_MODE = 1'b0;  // word index of client_mode

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HDR_M   = 3'd1,
        PH_HDR_DIR = 3'd2,
        PH_SIZE    = 3'd3,
        PH_CMD     = 3'd4,
        PH_DATA    = 3'd5
    } t_phase;

    typedef enum logic {
        ST_IN   = 1'b0,
        ST_EMIT = 1'b1
    } t_ctl_state;

endpackage

// ----- sv/mspfr_ram.sv -----
// ============================================================================
// mspfr_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ============================================================================
module mspfr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/msp_frame_receiver.sv -----
// ============================================================================
// msp_frame_receiver
// MSP v1 frame parser: header check, payload capture, checksum, delivery.
// ============================================================================
// Takes one received serial byte per input item and tracks MSP v1 frames
// ('$' 'M' direction size command payload checksum). Every byte yields one
// result, except the checksum byte of a good frame carrying N > 0 payload
// bytes, which yields N results streamed out of the payload RAM in order,
// the final one flagged with last. A byte that is not '$' while idle comes
// back with consumed low. Bad headers, oversized frames and checksum errors
// silently drop the frame. Rate: one byte per cycle for bytes that yield one
// result, back to back, as long as the output register drains. A good frame
// with payload holds off input after its checksum byte while the single read
// port of the payload RAM delivers its bytes, one per cycle as long as the
// output register drains, then the block returns to taking input.
// client_mode (APB address 0, bit 0) picks which direction is accepted:
// 0 takes '<' command frames, 1 takes '>' reply frames. It must only be
// written while the block is idle.
// ============================================================================
`include "msp_frame_receiver_macros.svh"

module msp_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_consumed,
    output logic        o_frame_valid,
    output logic [7:0]  o_command,
    output logic [6:0]  o_payload_size,
    output logic [5:0]  o_byte_index,
    output logic [7:0]  o_payload_byte,
    output logic        o_byte_valid,
    output logic        o_last
);

    localparam int ADDR_W = mspfr_pkg::ADDR_W;
    localparam int SIZE_W = mspfr_pkg::SIZE_W;
    localparam int IDX_W  = mspfr_pkg::IDX_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic                   r_client_mode;
    mspfr_pkg::t_phase      r_phase,      n_phase;
    mspfr_pkg::t_ctl_state  r_st,         n_st;
    logic [SIZE_W-1:0]      r_frame_size, n_frame_size;
    logic [7:0]             r_frame_cmd,  n_frame_cmd;
    logic [SIZE_W-1:0]      r_bytes_rx,   n_bytes_rx;
    logic [7:0]             r_csum,       n_csum;

    // payload readout: issue counter and one pending RAM read
    logic [SIZE_W-1:0]      r_issue_cnt,  n_issue_cnt;
    logic                   r_pend,       n_pend;
    logic [ADDR_W-1:0]      r_pend_idx,   n_pend_idx;

    // output register
    logic                   r_out_valid,  n_out_valid;
    logic                   r_o_consumed, n_o_consumed;
    logic                   r_o_fvalid,   n_o_fvalid;
    logic [7:0]             r_o_cmd,      n_o_cmd;
    logic [SIZE_W-1:0]      r_o_size,     n_o_size;
    logic [IDX_W-1:0]       r_o_idx,      n_o_idx;
    logic [7:0]             r_o_byte,     n_o_byte;
    logic                   r_o_bvalid,   n_o_bvalid;
    logic                   r_o_last,     n_o_last;

    // ------------------------------------------------------------------
    // Config port
    // ------------------------------------------------------------------
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == mspfr_pkg::REG_CLIENT_MODE) ?
                    {31'd0, r_client_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_client_mode <= 1'b0;
        end else if (cfg_wr && paddr[2] == mspfr_pkg::REG_CLIENT_MODE) begin
            r_client_mode <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Payload RAM
    // ------------------------------------------------------------------
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;

    mspfr_ram #(
        .DEPTH (mspfr_pkg::PAYLOAD_MAX),
        .WIDTH (8)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic out_free;   // output register empty or emptying this cycle
    logic in_acc;
    logic pend_move;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_st == mspfr_pkg::ST_IN) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign pend_move  = r_pend && out_free;

    assign ram_wr_addr = r_bytes_rx[ADDR_W-1:0];
    assign ram_rd_addr = r_issue_cnt[ADDR_W-1:0];

    // ------------------------------------------------------------------
    // Parser and readout control
    // ------------------------------------------------------------------
    always_comb begin
        logic dir_ok;
        logic single;      // byte yields one ordinary result
        logic res_cons;
        logic res_empty;   // empty good frame result

        n_phase      = r_phase;
        n_st         = r_st;
        n_frame_size = r_frame_size;
        n_frame_cmd  = r_frame_cmd;
        n_bytes_rx   = r_bytes_rx;
        n_csum       = r_csum;
        n_issue_cnt  = r_issue_cnt;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;
        dir_ok       = 1'b0;
        single       = 1'b0;
        res_cons     = 1'b1;
        res_empty    = 1'b0;

        n_out_valid  = r_out_valid && i_out_stall;
        n_o_consumed = r_o_consumed;
        n_o_fvalid   = r_o_fvalid;
        n_o_cmd      = r_o_cmd;
        n_o_size     = r_o_size;
        n_o_idx      = r_o_idx;
        n_o_byte     = r_o_byte;
        n_o_bvalid   = r_o_bvalid;
        n_o_last     = r_o_last;

        unique case (r_st)
            mspfr_pkg::ST_IN: begin
                if (in_acc) begin
                    single = 1'b1;
                    case (r_phase)
                        mspfr_pkg::PH_HDR_M: begin
                            n_phase = (i_rx_byte == mspfr_pkg::CH_M) ?
                                      mspfr_pkg::PH_HDR_DIR : mspfr_pkg::PH_IDLE;
                        end
                        mspfr_pkg::PH_HDR_DIR: begin
                            dir_ok = (i_rx_byte == mspfr_pkg::CH_LT && !r_client_mode)
                                  || (i_rx_byte == mspfr_pkg::CH_GT && r_client_mode);
                            n_phase = dir_ok ? mspfr_pkg::PH_SIZE : mspfr_pkg::PH_IDLE;
                        end
                        mspfr_pkg::PH_SIZE: begin
                            if (i_rx_byte > 8'(mspfr_pkg::PAYLOAD_MAX)) begin
                                n_phase = mspfr_pkg::PH_IDLE;
                            end else begin
                                n_frame_size = i_rx_byte[SIZE_W-1:0];
                                n_bytes_rx   = '0;
                                n_csum       = i_rx_byte;
                                n_phase      = mspfr_pkg::PH_CMD;
                            end
                        end
                        mspfr_pkg::PH_CMD: begin
                            n_frame_cmd = i_rx_byte;
                            n_csum      = r_csum ^ i_rx_byte;
                            n_phase     = mspfr_pkg::PH_DATA;
                        end
                        mspfr_pkg::PH_DATA: begin
                            if (r_bytes_rx < r_frame_size &&
                                r_bytes_rx < SIZE_W'(mspfr_pkg::PAYLOAD_MAX)) begin
                                ram_wr_en  = 1'b1;
                                n_bytes_rx = r_bytes_rx + SIZE_W'(1);
                                n_csum     = r_csum ^ i_rx_byte;
                            end else begin
                                n_phase = mspfr_pkg::PH_IDLE;
                                if (i_rx_byte == r_csum) begin
                                    if (r_frame_size == '0) begin
                                        res_empty = 1'b1;
                                    end else begin
                                        // stream the payload out of RAM
                                        single      = 1'b0;
                                        n_st        = mspfr_pkg::ST_EMIT;
                                        n_issue_cnt = '0;
                                        n_pend      = 1'b0;
                                    end
                                end
                            end
                        end
                        default: begin
                            // idle and unused codes
                            if (i_rx_byte != mspfr_pkg::CH_START) begin
                                res_cons = 1'b0;
                            end else begin
                                n_phase = mspfr_pkg::PH_HDR_M;
                            end
                        end
                    endcase

                    if (single) begin
                        n_out_valid  = 1'b1;
                        n_o_consumed = res_cons;
                        n_o_fvalid   = res_empty;
                        n_o_cmd      = res_empty ? r_frame_cmd : 8'd0;
                        n_o_size     = '0;
                        n_o_idx      = '0;
                        n_o_byte     = 8'd0;
                        n_o_bvalid   = 1'b0;
                        n_o_last     = 1'b1;
                    end
                end
            end
            mspfr_pkg::ST_EMIT: begin
                // RAM read data -> output register
                if (pend_move) begin
                    n_out_valid  = 1'b1;
                    n_o_consumed = 1'b1;
                    n_o_fvalid   = 1'b1;
                    n_o_cmd      = r_frame_cmd;
                    n_o_size     = r_frame_size;
                    n_o_idx      = IDX_W'(r_pend_idx);
                    n_o_byte     = ram_rd_data;
                    n_o_bvalid   = 1'b1;
                    n_o_last     = (SIZE_W'(r_pend_idx) + SIZE_W'(1)) == r_frame_size;
                    n_pend       = 1'b0;
                end
                // next RAM read
                if (r_issue_cnt < r_frame_size && (!r_pend || pend_move)) begin
                    ram_rd_en   = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_idx  = r_issue_cnt[ADDR_W-1:0];
                    n_issue_cnt = r_issue_cnt + SIZE_W'(1);
                end
                if (r_issue_cnt == r_frame_size && !r_pend) begin
                    n_st = mspfr_pkg::ST_IN;
                end
            end
            default: begin
                n_st = mspfr_pkg::ST_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mspfr_pkg::PH_IDLE;
            r_st         <= mspfr_pkg::ST_IN;
            r_frame_size <= '0;
            r_frame_cmd  <= 8'd0;
            r_bytes_rx   <= '0;
            r_csum       <= 8'd0;
            r_issue_cnt  <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_st         <= n_st;
            r_frame_size <= n_frame_size;
            r_frame_cmd  <= n_frame_cmd;
            r_bytes_rx   <= n_bytes_rx;
            r_csum       <= n_csum;
            r_issue_cnt  <= n_issue_cnt;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_pend_idx   <= n_pend_idx;
        r_o_consumed <= n_o_consumed;
        r_o_fvalid   <= n_o_fvalid;
        r_o_cmd      <= n_o_cmd;
        r_o_size     <= n_o_size;
        r_o_idx      <= n_o_idx;
        r_o_byte     <= n_o_byte;
        r_o_bvalid   <= n_o_bvalid;
        r_o_last     <= n_o_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_consumed     = r_o_consumed;
    assign o_frame_valid  = r_o_fvalid;
    assign o_command      = r_o_cmd;
    assign o_payload_size = r_o_size;
    assign o_byte_index   = r_o_idx;
    assign o_payload_byte = r_o_byte;
    assign o_byte_valid   = r_o_bvalid;
    assign o_last         = r_o_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MSPFR_ASSERT(a_no_input_in_emit, (r_st == mspfr_pkg::ST_EMIT) |-> o_in_stall, "input taken during payload readout")
    `MSPFR_ASSERT(a_emit_nonempty, (r_st == mspfr_pkg::ST_EMIT) |-> (r_frame_size != '0), "readout of empty frame")
    `MSPFR_ASSERT(a_issue_bound, (r_st == mspfr_pkg::ST_EMIT) |-> (r_issue_cnt <= r_frame_size), "readout ran past frame size")
    `MSPFR_ASSERT(a_pend_in_range, r_pend |-> (SIZE_W'(r_pend_idx) < r_frame_size), "pending read index out of range")
    `MSPFR_ASSERT(a_byte_needs_frame, (r_out_valid && r_o_bvalid) |-> (r_o_fvalid && r_o_consumed), "payload byte outside a good frame")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the MSP v1 frame receiver.
// ============================================================================
// A stream of serial bytes is sent into the block. The stream holds directed
// header and frame cases, then random traffic. Most of the random traffic is
// well-formed frames with random content. The rest is noise, bad checksums,
// wrong directions, oversized sizes and truncated headers. Each accepted byte
// runs through a frame parser kept here, which queues the results the block
// owes. Each result the block delivers is checked field by field against the
// oldest queued result. The run covers server and client mode, with random
// idle and stall on both sides, a long output hold-off and quiet pauses.
// ============================================================================
module testbench;

    localparam int HOLDOFF_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 8;    // pause before a config write
    localparam int TAIL_CYCLES    = 70;   // longest frame plus read latency
    localparam logic [2:0] CLIENT_MODE_ADDR =
        3'(4 * int'(mspfr_pkg::REG_CLIENT_MODE));
    localparam logic [2:0] UNUSED_ADDR      = 3'd4;

    // One result of the block, in port order
    typedef struct packed {
        logic                         consumed;
        logic                         frame_valid;
        logic [7:0]                   command;
        logic [mspfr_pkg::SIZE_W-1:0] payload_size;
        logic [mspfr_pkg::IDX_W-1:0]  byte_index;
        logic [7:0]                   payload_byte;
        logic                         byte_valid;
        logic                         last;
    } t_msp_result;

    // Clock, reset and block ports
    logic        i_clk;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte  = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        o_consumed, o_frame_valid, o_byte_valid, o_last;
    logic [7:0]  o_command, o_payload_byte;
    logic [6:0]  o_payload_size;
    logic [5:0]  o_byte_index;

    // Bytes waiting to be sent, results the block still owes
    logic [7:0]  tx_bytes[$];
    t_msp_result expected_results[$];

    // Traffic shaping, written by the sequence, read by driver and monitor
    int src_idle_pct = 0;
    int rcv_idle_pct = 0;
    int holdoff_req  = 0;
    int holdoff_ack  = 0;
    int holdoff_left = 0;

    int err_cnt      = 0;
    int result_cnt   = 0;
    int cycle_cnt    = 0;
    int bytes_queued = 0;

    // Parser state mirrored from the frame format
    mspfr_pkg::t_phase p_phase  = mspfr_pkg::PH_IDLE;
    logic              p_client = 1'b0;
    logic [6:0]        p_size   = '0;
    logic [7:0]        p_cmd    = '0;
    logic [6:0]        p_count  = '0;
    logic [7:0]        p_sum    = '0;
    logic [7:0]        p_store[mspfr_pkg::PAYLOAD_MAX];

    msp_frame_receiver u_top (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_consumed     (o_consumed),
        .o_frame_valid  (o_frame_valid),
        .o_command      (o_command),
        .o_payload_size (o_payload_size),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_byte_valid   (o_byte_valid),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                    result_cnt, name, got, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // Frame parser: one received byte in, the owed results queued.
    // Every byte owes one plain result, except the checksum byte of a good
    // frame with payload, which owes one result per payload byte.
    // ------------------------------------------------------------------------
    task automatic parse_byte(input logic [7:0] c);
        t_msp_result r;
        bit          burst;
        r          = '0;
        r.consumed = 1'b1;
        r.last     = 1'b1;
        burst      = 1'b0;
        case (p_phase)
            mspfr_pkg::PH_HDR_M: begin
                p_phase = (c == mspfr_pkg::CH_M) ? mspfr_pkg::PH_HDR_DIR
                                                 : mspfr_pkg::PH_IDLE;
            end
            mspfr_pkg::PH_HDR_DIR: begin
                p_phase = ((c == mspfr_pkg::CH_LT && !p_client) ||
                           (c == mspfr_pkg::CH_GT && p_client))
                          ? mspfr_pkg::PH_SIZE : mspfr_pkg::PH_IDLE;
            end
            mspfr_pkg::PH_SIZE: begin
                if (c > mspfr_pkg::PAYLOAD_MAX) begin
                    p_phase = mspfr_pkg::PH_IDLE;      // oversized: drop silently
                end else begin
                    p_size  = c[6:0];
                    p_count = '0;
                    p_sum   = c;
                    p_phase = mspfr_pkg::PH_CMD;
                end
            end
            mspfr_pkg::PH_CMD: begin
                p_cmd   = c;
                p_sum   = p_sum ^ c;
                p_phase = mspfr_pkg::PH_DATA;
            end
            mspfr_pkg::PH_DATA: begin
                if (p_count < p_size && p_count < mspfr_pkg::PAYLOAD_MAX) begin
                    p_store[p_count[5:0]] = c;
                    p_count = p_count + 1'b1;
                    p_sum   = p_sum ^ c;
                end else begin
                    // checksum byte
                    p_phase = mspfr_pkg::PH_IDLE;
                    if (c == p_sum) begin
                        if (p_size == 0) begin
                            r.frame_valid = 1'b1;
                            r.command     = p_cmd;
                        end else begin
                            burst = 1'b1;
                            for (int k = 0; k < p_size; k++) begin
                                r.frame_valid  = 1'b1;
                                r.command      = p_cmd;
                                r.payload_size = p_size;
                                r.byte_index   = mspfr_pkg::IDX_W'(k);
                                r.payload_byte = p_store[k];
                                r.byte_valid   = 1'b1;
                                r.last         = (k == p_size - 1);
                                expected_results.push_back(r);
                            end
                        end
                    end
                end
            end
            default: begin
                // idle and unused phase codes
                if (c != mspfr_pkg::CH_START) begin
                    r.consumed = 1'b0;
                end else begin
                    p_phase = mspfr_pkg::PH_HDR_M;
                end
            end
        endcase
        if (!burst) begin
            expected_results.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: offers queued bytes, with random idle cycles
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                parse_byte(rx_byte);
            end
            // a held byte stays put until taken
            if (!in_valid || !in_stall) begin
                if (tx_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    rx_byte  <= tx_bytes.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: checks each taken result, drives the output stall.
    // A hold-off request holds the output stall high until holdoff_left counts down to zero.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_msp_result got, want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = {o_consumed, o_frame_valid, o_command, o_payload_size,
                       o_byte_index, o_payload_byte, o_byte_valid, o_last};
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf("result %0d arrived with none owed",
                                            result_cnt));
                end else begin
                    want = expected_results.pop_front();
                    compare_field("consumed",     8'(got.consumed),     8'(want.consumed));
                    compare_field("frame_valid",  8'(got.frame_valid),  8'(want.frame_valid));
                    compare_field("command",      got.command,          want.command);
                    compare_field("payload_size", 8'(got.payload_size), 8'(want.payload_size));
                    compare_field("byte_index",   8'(got.byte_index),   8'(want.byte_index));
                    compare_field("payload_byte", got.payload_byte,     want.payload_byte);
                    compare_field("byte_valid",   8'(got.byte_valid),   8'(want.byte_valid));
                    compare_field("last",         8'(got.last),         8'(want.last));
                end
                result_cnt++;
            end
            if (holdoff_req != holdoff_ack) begin
                holdoff_ack  = holdoff_req;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("watchdog: %0d results owed, %0d bytes unsent",
                     expected_results.size(), tx_bytes.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_queued++;
    endtask

    // Full frame; an oversized size byte ends it right there
    task automatic queue_frame(input logic [7:0] dir, input logic [7:0] size,
                               input logic [7:0] cmd, input bit bad_sum);
        logic [7:0] sum, b;
        push_byte(mspfr_pkg::CH_START);
        push_byte(mspfr_pkg::CH_M);
        push_byte(dir);
        push_byte(size);
        if (size <= mspfr_pkg::PAYLOAD_MAX) begin
            push_byte(cmd);
            sum = size ^ cmd;
            for (int k = 0; k < size; k++) begin
                b = 8'($urandom);
                push_byte(b);
                sum = sum ^ b;
            end
            if (bad_sum) begin
                sum = sum ^ 8'($urandom_range(1, 255));
            end
            push_byte(sum);
        end
    endtask

    // Random mix, mostly good frames of small size
    task automatic queue_traffic(input int n_bytes, input logic [7:0] good_dir);
        int         start, pick, size;
        logic [7:0] bad_dir;
        start   = bytes_queued;
        bad_dir = (good_dir == mspfr_pkg::CH_LT) ? mspfr_pkg::CH_GT : mspfr_pkg::CH_LT;
        while (bytes_queued - start < n_bytes) begin
            pick = $urandom_range(99);
            size = ($urandom_range(9) == 0) ? $urandom_range(9, mspfr_pkg::PAYLOAD_MAX)
                                            : $urandom_range(0, 8);
            if (pick < 60) begin
                queue_frame(good_dir, 8'(size), 8'($urandom), 1'b0);
            end else if (pick < 70) begin
                queue_frame(good_dir, 8'(size), 8'($urandom), 1'b1);
            end else if (pick < 75) begin
                queue_frame($urandom_range(1) ? bad_dir : 8'($urandom),
                            8'(size), 8'($urandom), 1'b0);
            end else if (pick < 80) begin
                queue_frame(good_dir,
                            8'($urandom_range(mspfr_pkg::PAYLOAD_MAX + 1, 255)),
                            8'($urandom), 1'b0);
            end else if (pick < 87) begin
                // header cut short, then whatever follows
                push_byte(mspfr_pkg::CH_START);
                if ($urandom_range(1)) begin
                    push_byte(mspfr_pkg::CH_M);
                    push_byte(good_dir);
                end
                repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
            end else begin
                push_byte(8'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        while (tx_bytes.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // APB write, then read back client_mode
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == CLIENT_MODE_ADDR) begin
            p_client = data[0];
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CLIENT_MODE_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[0] !== p_client) begin
            note_mismatch($sformatf("client_mode reads %0b, want %0b",
                                    prdata[0], p_client));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;

        // Server mode, sender idles 31%, receiver 45%
        src_idle_pct <= 31;
        rcv_idle_pct <= 45;
        write_reg(CLIENT_MODE_ADDR, 32'd0);
        push_byte(8'h00);                   // idle noise, not consumed
        push_byte(8'hFF);
        push_byte(mspfr_pkg::CH_START);     // second start where M is due
        push_byte(mspfr_pkg::CH_START);
        push_byte(mspfr_pkg::CH_M);
        push_byte(mspfr_pkg::CH_START);     // direction of the other mode
        push_byte(mspfr_pkg::CH_M);
        push_byte(mspfr_pkg::CH_GT);
        queue_frame(mspfr_pkg::CH_LT, 8'(mspfr_pkg::PAYLOAD_MAX + 1), 8'h00,
                    1'b0);                                    // oversized
        queue_frame(mspfr_pkg::CH_LT, 8'd0, 8'hFF, 1'b0);     // empty frame
        queue_frame(mspfr_pkg::CH_LT, 8'd1, 8'h00, 1'b0);     // one byte
        queue_frame(mspfr_pkg::CH_LT, 8'd1, 8'h5A, 1'b1);     // bad checksum
        wait_drained();                     // sender pauses until all is back
        queue_traffic(12, mspfr_pkg::CH_LT);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Client mode, idle ratios swapped
        src_idle_pct <= 45;
        rcv_idle_pct <= 31;
        write_reg(UNUSED_ADDR, 32'hFFFF_FFFF);   // no register there
        write_reg(CLIENT_MODE_ADDR, 32'd1);
        queue_frame(mspfr_pkg::CH_LT, 8'd2, 8'h11, 1'b0);   // server frame, dropped
        queue_frame(mspfr_pkg::CH_GT, 8'd2, 8'hC3, 1'b0);
        queue_frame(mspfr_pkg::CH_GT, 8'(mspfr_pkg::PAYLOAD_MAX), 8'h7E,
                    1'b0);                                  // largest frame
        wait_drained();
        queue_traffic(14, mspfr_pkg::CH_GT);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Server mode, no idling; output held off long enough to back up
        src_idle_pct <= 0;
        rcv_idle_pct <= 0;
        write_reg(CLIENT_MODE_ADDR, 32'd0);
        holdoff_req <= holdoff_req + 1;
        queue_traffic(10, mspfr_pkg::CH_LT);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Client mode again, still no idling
        write_reg(CLIENT_MODE_ADDR, 32'd1);
        queue_traffic(6, mspfr_pkg::CH_GT);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived",
                                    expected_results.size()));
        end
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
